@@ src/schn_pkg.sv @@
package schn_pkg;

  // Register file layout
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned HashW     = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned HashBitsW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SALT      = 2'd0,
    CFG_POLY      = 2'd1,
    CFG_HASH_BITS = 2'd2
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [HashW-1:0]     SaltReset     = 64'h0000_0000_0000_0001;
  localparam logic [HashW-1:0]     PolyReset     = 64'hC96C_5795_D787_0F42;
  localparam logic [HashBitsW-1:0] HashBitsReset = 7'd28;

  typedef logic [HashW-1:0] hash_t;
  typedef logic [ByteW-1:0] byte_t;

  // CRC of one byte: eight reflected shift/XOR steps with the given polynomial
  function automatic hash_t byte_crc(input byte_t idx, input hash_t poly);
    hash_t v;
    v = {{(HashW-ByteW){1'b0}}, idx};
    for (int k = 0; k < ByteW; k++) begin
      v = (v >> 1) ^ (v[0] ? poly : '0);
    end
    return v;
  endfunction

  // One full CRC-64 byte update of the running value
  function automatic hash_t crc_update(input hash_t crc, input byte_t b, input hash_t poly);
    return (crc >> ByteW) ^ byte_crc(crc[ByteW-1:0] ^ b, poly);
  endfunction

  // Keep only the top hash_bits bits; 64 and above keep everything
  function automatic hash_t keep_mask(input logic [HashBitsW-1:0] hb);
    hash_t m;
    if (hb >= HashBitsW'(HashW)) begin
      m = '1;
    end else begin
      m = ~({HashW{1'b1}} >> hb);
    end
    return m;
  endfunction

endpackage

@@ src/salted_crc64_name_hash.sv @@
// Salted CRC-64 name hash, one name byte per request.
// A terminating zero byte is held in the input register, and its hash is then written into
// the result register; the byte waits while an untaken hash blocks the result register.
// Throughput: one byte per cycle while no end of name is blocked; the eight CRC bit steps
// sit in one stage between the input register and the running-value register.
// Reset: salt = 1, polynomial = 0xC96C5795D7870F42, hash_bits = 28, running
// value = 1, input and output stages empty.
module salted_crc64_name_hash (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Name byte channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [schn_pkg::ByteW-1:0]         name_byte_i,
  // Hash channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [schn_pkg::HashW-1:0]         hash_value_o,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [schn_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [schn_pkg::CfgDataW-1:0]      cfg_data_i
);
  import schn_pkg::*;

  hash_t                 salt_q, poly_q;
  logic [HashBitsW-1:0]  hash_bits_q;
  hash_t                 crc_q, crc_d;
  logic                  s1_valid_q, s1_valid_d;
  byte_t                 s1_byte_q;
  logic                  out_valid_q, out_valid_d;
  hash_t                 out_hash_q, out_hash_d;
  logic                  out_free;
  logic                  s1_fire;
  logic                  s1_end;
  logic                  in_accept;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_end     = (s1_byte_q == '0);
  assign s1_fire    = s1_valid_q && (!s1_end || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q      <= SaltReset;
      poly_q      <= PolyReset;
      hash_bits_q <= HashBitsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SALT:      salt_q      <= cfg_data_i;
        CFG_POLY:      poly_q      <= cfg_data_i;
        CFG_HASH_BITS: hash_bits_q <= cfg_data_i[HashBitsW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= name_byte_i;
    end
  end

  // Running value: CRC update on a nonzero byte, salt reload at end of name, new salt on a salt write
  always_comb begin
    crc_d = crc_q;
    if (cfg_we_i && cfg_index_i == CFG_SALT) begin
      crc_d = cfg_data_i;
    end else if (s1_fire) begin
      crc_d = s1_end ? salt_q : crc_update(crc_q, s1_byte_q, poly_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= SaltReset;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_hash_d  = out_hash_q;
    if (s1_fire && s1_end) begin
      out_valid_d = 1'b1;
      out_hash_d  = crc_q & keep_mask(hash_bits_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

  // Checks
  a_reload_salt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_end && !cfg_we_i |=> crc_q == $past(salt_q))
    else $error("running value not reloaded with salt after end of name");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_end |=> out_valid_q)
    else $error("end of name produced no result");

  a_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_end && out_free |=> !out_valid_q)
    else $error("nonzero byte produced a result");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_end && !out_free)
    else $error("input stalled without a blocked end of name");

endmodule

@@ sim/salted_crc64_name_hash_test.sv @@
`timescale 1ns / 100ps

module salted_crc64_name_hash_test;
  import schn_pkg::*;

  // Index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam byte_t NameEnd = 8'h00;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    name_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [HashW-1:0]    hash_value_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  salted_crc64_name_hash dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_byte_i  (name_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the hash engine
  hash_t                salt_q      = SaltReset;
  hash_t                poly_q      = PolyReset;
  logic [HashBitsW-1:0] hash_bits_q = HashBitsReset;
  hash_t                name_crc    = SaltReset;

  byte_t pending_bytes[$];
  hash_t expected_hashes[$];
  int    error_count = 0;
  bit    idle_off = 1'b0;
  int    hold_token = 0;

  // Reflected CRC-64 update of the running value by one byte
  function automatic hash_t crc_step(input hash_t crc, input byte_t b);
    hash_t v;
    int    k;
    v = {{(HashW-ByteW){1'b0}}, crc[ByteW-1:0] ^ b};
    for (k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ poly_q) : (v >> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

  // Clear all but the top hash_bits bits
  function automatic hash_t top_bits(input hash_t v);
    int unsigned sh;
    hash_t       m;
    if (hash_bits_q == 0) begin
      m = '0;
    end else if (hash_bits_q >= 7'd64) begin
      m = '1;
    end else begin
      sh = 64 - hash_bits_q;
      m = ~((64'd1 << sh) - 64'd1);
    end
    return v & m;
  endfunction

  // Fold one accepted byte into the shadow; a name end yields a hash
  function automatic void absorb_byte(input byte_t b);
    if (b != NameEnd) begin
      name_crc = crc_step(name_crc, b);
    end else begin
      expected_hashes.push_back(top_bits(name_crc));
      name_crc = salt_q;
    end
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_off) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Request driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      name_byte_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) absorb_byte(name_byte_i);
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid_i  <= 1'b1;
        name_byte_i <= pending_bytes.pop_front();
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned hold_left = 0;
  int          hold_seen = 0;
  hash_t       want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: no hash expected, got %h", hash_value_o);
          error_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value_o !== want) begin
            $error("hash_value: expected %h, got %h", want, hash_value_o);
            error_count++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 80;
      end
      if (stall_left == 0 && run_left == 0) begin
        stall_left = pick_gap();
        run_left   = $urandom_range(1, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        run_left--;
        out_stall_i <= 1'b0;
      end
    end
  end

  // Register write; the shadow follows at the write edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input hash_t data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SALT: begin
        salt_q   = data;
        name_crc = data;
      end
      CFG_POLY:      poly_q = data;
      CFG_HASH_BITS: hash_bits_q = data[HashBitsW-1:0];
      default: ;
    endcase
  endtask

  // Wait until every request is taken and every hash is back, then let the pipe empty
  task automatic drain();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_hashes.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic hash_t pick_word(input hash_t alt);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return alt;
    return {$urandom, $urandom};
  endfunction

  // New salt, polynomial and hash width, in random order
  task automatic random_config(input bit touch_unused);
    hash_t       hb;
    int unsigned r;
    int unsigned first;
    int unsigned i;
    r  = $urandom_range(0, 7);
    hb = {$urandom, $urandom};
    case (r)
      0: hb[6:0] = 7'd0;
      1: hb[6:0] = 7'd1;
      2: hb[6:0] = 7'd63;
      3: hb[6:0] = 7'd64;
      4: hb[6:0] = 7'd127;
      default: hb[6:0] = 7'($urandom_range(0, 127));
    endcase
    first = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      case ((first + i) % 3)
        0: write_reg(CFG_SALT, pick_word(SaltReset));
        1: write_reg(CFG_POLY, pick_word(PolyReset));
        default: write_reg(CFG_HASH_BITS, hb);
      endcase
    end
    if (touch_unused) write_reg(CfgUnused, {$urandom, $urandom});
  endtask

  // Mostly terminated names with random content, the rest loose bytes
  task automatic queue_names(input int unsigned n_items, input int unsigned max_len);
    int unsigned count;
    int unsigned len;
    int unsigned j;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                           : $urandom_range(0, max_len);
        for (j = 0; j < len; j++) pending_bytes.push_back(byte_t'($urandom_range(1, 255)));
        pending_bytes.push_back(NameEnd);
        count += len + 1;
      end else begin
        pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
        count++;
      end
    end
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: empty name, extreme bytes, a mixed name
    pending_bytes.push_back(NameEnd);
    pending_bytes.push_back(8'h01); pending_bytes.push_back(NameEnd);
    pending_bytes.push_back(8'hFF); pending_bytes.push_back(NameEnd);
    pending_bytes.push_back(8'h80); pending_bytes.push_back(8'h7F);
    pending_bytes.push_back(8'h55); pending_bytes.push_back(8'hAA);
    pending_bytes.push_back(NameEnd);
    drain();

    // No bits kept
    write_reg(CFG_HASH_BITS, 64'hFFFF_FFFF_FFFF_FF80);
    pending_bytes.push_back(8'h41); pending_bytes.push_back(NameEnd);
    drain();

    // All bits kept, then a width above 64
    write_reg(CFG_HASH_BITS, 64'd64);
    pending_bytes.push_back(8'h41); pending_bytes.push_back(NameEnd);
    drain();
    write_reg(CFG_HASH_BITS, 64'h8000_0000_0000_0064);
    pending_bytes.push_back(8'h42); pending_bytes.push_back(NameEnd);
    drain();

    // Zero salt, all-ones polynomial, one bit kept
    write_reg(CFG_HASH_BITS, 64'd1);
    write_reg(CFG_SALT, 64'd0);
    write_reg(CFG_POLY, '1);
    pending_bytes.push_back(NameEnd);
    pending_bytes.push_back(8'h10); pending_bytes.push_back(NameEnd);
    drain();

    // Partial name dropped by a salt write
    write_reg(CFG_HASH_BITS, 64'd64);
    write_reg(CFG_SALT, '1);
    write_reg(CFG_POLY, 64'd0);
    pending_bytes.push_back(8'h33); pending_bytes.push_back(8'h44);
    drain();
    write_reg(CFG_SALT, '1);
    pending_bytes.push_back(NameEnd);
    drain();

    // Write to the unused index changes nothing
    write_reg(CFG_POLY, PolyReset);
    write_reg(CfgUnused, '1);
    pending_bytes.push_back(8'h5A); pending_bytes.push_back(NameEnd);
    drain();

    // Random phases
    for (p = 0; p < 8; p++) begin
      random_config(p % 3 == 0);
      @(negedge clk_i);
      idle_off = (p == 2) || (p == 5);
      if (p == 5) begin
        // Receiver holds off while short names keep coming
        hold_token++;
        queue_names(60, 2);
      end else begin
        queue_names(85, 12);
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
